@@ design/ihc_pkg.sv @@
// ----------------------------------------------------------------------------
// ihc_pkg: shared types and constants for the IPv4 header check core
// Word layouts on the streaming ports, verdict codes and protocol numbers.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // Header constants
    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;

    // Verdict codes, in order of check priority after deliver
    typedef enum logic [2:0] {
        V_DELIVER       = 3'd0,
        V_TOO_SHORT     = 3'd1,
        V_BAD_VERSION   = 3'd2,
        V_BAD_LENGTH    = 3'd3,
        V_BAD_CSUM      = 3'd4,
        V_NOT_OURS      = 3'd5,
        V_PROTO_UNREACH = 3'd6
    } t_verdict;

    // One input word as held in the input register
    typedef struct packed {
        logic [15:0] frame_length;
        logic        start_req;
        logic [15:0] header_word;
    } t_in_word;

    // One result word as held in the output register
    typedef struct packed {
        logic [15:0] padding_length;
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [7:0]  protocol;
        t_verdict    verdict;
    } t_result;

endpackage

@@ design/ipv4_header_check_core.sv @@
// The tenth header word leaves the input register and its verdict loads the result register.
// Throughput: one header word per cycle unless a last word waits on a stalled result register.
// A full header arrives as ten 16-bit words on the input port.
// Reset is synchronous, active low: clears the word counter, both stage valids
// and the local address register.
// ----------------------------------------------------------------------------
// ipv4_header_check_core: IPv4 header validation
// Sums and captures a 20-byte header word by word and reports one verdict.
// ----------------------------------------------------------------------------
module ipv4_header_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Local address register
    input  logic        i_local_addr_we,
    input  logic [31:0] i_local_addr_wdata,
    // Header words in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] header_word, [31:16] frame_length
    input  logic [0:0]  s_axis_tuser,   // [0] start_req
    // Verdict words out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] protocol, [39:8] source_address,
                                        // [55:40] payload_length, [71:56] padding_length
    output logic [2:0]  m_axis_tuser    // [2:0] verdict
);
    import ihc_pkg::*;

    logic [31:0] r_local_addr;
    t_in_word    in_word;
    t_in_word    held_word;
    logic        held_valid;
    logic        res_pending;
    logic        out_free;
    logic        advance;
    t_result     eval_result;
    t_result     out_result;

    // Local address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= 32'd0;
        end else if (i_local_addr_we) begin
            r_local_addr <= i_local_addr_wdata;
        end
    end

    // Unpack the input word
    assign in_word.header_word  = s_axis_tdata[15:0];
    assign in_word.frame_length = s_axis_tdata[31:16];
    assign in_word.start_req    = s_axis_tuser[0];

    // Held word moves on unless it carries a result with nowhere to go
    assign advance = held_valid && (!res_pending || out_free);

    ihc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_word    (in_word),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    ihc_hdr_eval u_hdr_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (advance),
        .i_word        (held_word),
        .i_local_addr  (r_local_addr),
        .o_res_pending (res_pending),
        .o_result      (eval_result)
    );

    ihc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && res_pending),
        .i_result (eval_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // Pack the result word
    assign m_axis_tdata = {out_result.padding_length, out_result.payload_length,
                           out_result.source_address, out_result.protocol};
    assign m_axis_tuser = out_result.verdict;

endmodule

@@ design/ihc_in_stage.sv @@
// ----------------------------------------------------------------------------
// ihc_in_stage: input register
// Holds one accepted header word until the evaluation stage consumes it.
// ----------------------------------------------------------------------------
module ihc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ihc_pkg::t_in_word i_word,
    input  logic            i_advance,
    output logic            o_valid,
    output ihc_pkg::t_in_word o_word
);
    import ihc_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     accept;

    // Free when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ design/ihc_hdr_eval.sv @@
// ----------------------------------------------------------------------------
// ihc_hdr_eval: header field capture, checksum and verdict
// Keeps the per-packet state and forms the verdict on the last header word.
// ----------------------------------------------------------------------------
module ihc_hdr_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ihc_pkg::t_in_word i_word,
    input  logic [31:0]       i_local_addr,
    output logic              o_res_pending,
    output ihc_pkg::t_result  o_result
);
    import ihc_pkg::*;

    // Word positions within the header
    localparam logic [3:0] POS_VER_IHL = 4'd0;
    localparam logic [3:0] POS_TOT_LEN = 4'd1;
    localparam logic [3:0] POS_PROTO   = 4'd4;
    localparam logic [3:0] POS_CSUM    = 4'd5;
    localparam logic [3:0] POS_SRC_HI  = 4'd6;
    localparam logic [3:0] POS_SRC_LO  = 4'd7;
    localparam logic [3:0] POS_DST_HI  = 4'd8;
    localparam logic [3:0] POS_DST_LO  = 4'd9;
    localparam logic [3:0] POS_LAST    = 4'd9;

    logic [3:0]  r_word_count, n_word_count;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_ver_ihl, n_ver_ihl;
    logic [15:0] r_total_len, n_total_len;
    logic [7:0]  r_protocol, n_protocol;
    logic [15:0] r_stored_csum, n_stored_csum;
    logic [31:0] r_source, n_source;
    logic        r_dest_mismatch, n_dest_mismatch;
    logic [15:0] r_frame_len, n_frame_len;

    logic [3:0]  pos;
    logic [15:0] w;
    logic [15:0] base_sum;
    logic [16:0] raw_sum;
    logic        active;
    logic [15:0] ihl_bytes;
    t_verdict    verdict;

    assign w      = i_word.header_word;
    assign pos    = i_word.start_req ? POS_VER_IHL : r_word_count;
    // A word outside a packet is dropped
    assign active = i_valid && (i_word.start_req || (r_word_count != POS_VER_IHL));

    // Next packet state for the word at hand
    always_comb begin
        n_ver_ihl       = r_ver_ihl;
        n_total_len     = r_total_len;
        n_protocol      = r_protocol;
        n_stored_csum   = r_stored_csum;
        n_source        = r_source;
        n_dest_mismatch = i_word.start_req ? 1'b0 : r_dest_mismatch;
        n_frame_len     = i_word.start_req ? i_word.frame_length : r_frame_len;
        base_sum        = i_word.start_req ? 16'd0 : r_sum;

        case (pos)
            POS_VER_IHL: n_ver_ihl     = w[15:8];
            POS_TOT_LEN: n_total_len   = w;
            POS_PROTO:   n_protocol    = w[7:0];
            POS_CSUM:    n_stored_csum = w;
            POS_SRC_HI:  n_source      = {w, r_source[15:0]};
            POS_SRC_LO:  n_source      = {r_source[31:16], w};
            POS_DST_HI: begin
                if (w != i_local_addr[31:16]) n_dest_mismatch = 1'b1;
            end
            POS_DST_LO: begin
                if (w != i_local_addr[15:0]) n_dest_mismatch = 1'b1;
            end
            default: ;
        endcase

        // Ones' complement add with end-around carry, checksum word skipped
        raw_sum = {1'b0, base_sum} + {1'b0, w};
        if (pos == POS_CSUM) begin
            n_sum = base_sum;
        end else begin
            n_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};
        end

        n_word_count = (pos == POS_LAST) ? 4'd0 : pos + 4'd1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= 4'd0;
        end else if (active) begin
            r_word_count <= n_word_count;
        end
    end

    // Captured header fields
    always_ff @(posedge i_clk) begin
        if (active) begin
            r_sum           <= n_sum;
            r_ver_ihl       <= n_ver_ihl;
            r_total_len     <= n_total_len;
            r_protocol      <= n_protocol;
            r_stored_csum   <= n_stored_csum;
            r_source        <= n_source;
            r_dest_mismatch <= n_dest_mismatch;
            r_frame_len     <= n_frame_len;
        end
    end

    // Verdict, first failing check wins
    assign ihl_bytes = {10'd0, n_ver_ihl[3:0], 2'b00};

    always_comb begin
        if (n_frame_len <= ihl_bytes) begin
            verdict = V_TOO_SHORT;
        end else if (n_ver_ihl[7:4] != IPV4_VERSION) begin
            verdict = V_BAD_VERSION;
        end else if (n_total_len > n_frame_len) begin
            verdict = V_BAD_LENGTH;
        end else if (~n_sum != n_stored_csum) begin
            verdict = V_BAD_CSUM;
        end else if (n_dest_mismatch) begin
            verdict = V_NOT_OURS;
        end else if (n_protocol == PROTO_UDP || n_protocol == PROTO_ICMP) begin
            verdict = V_DELIVER;
        end else begin
            verdict = V_PROTO_UNREACH;
        end
    end

    // Result fields
    always_comb begin
        o_result.verdict        = verdict;
        o_result.protocol       = n_protocol;
        o_result.source_address = n_source;
        o_result.payload_length = (n_total_len > HDR_BYTES) ? n_total_len - HDR_BYTES : 16'd0;
        o_result.padding_length = (n_frame_len > n_total_len) ?
                                  n_frame_len - n_total_len : 16'd0;
    end

    // The held word is the last of its header
    assign o_res_pending = !i_word.start_req && (r_word_count == POS_LAST);

endmodule

@@ design/ihc_out_stage.sv @@
// ----------------------------------------------------------------------------
// ihc_out_stage: result register
// Holds one verdict word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ihc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ihc_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ihc_pkg::t_result o_result
);
    import ihc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/ihc_checker.sv @@
// ----------------------------------------------------------------------------
// ihc_checker: port-level checks for the IPv4 header check core
// Watches the result port over time; bound to the top level below.
// ----------------------------------------------------------------------------
module ihc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import ihc_pkg::*;

    // No result word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Stalled word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Deliver only for UDP or ICMP
    a_deliver_proto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == V_DELIVER) |->
            (m_axis_tdata[7:0] == PROTO_UDP) || (m_axis_tdata[7:0] == PROTO_ICMP))
        else $error("deliver verdict for another protocol");

    // Total length beyond the frame leaves nothing to strip
    a_bad_len_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == V_BAD_LENGTH) |-> (m_axis_tdata[71:56] == 16'd0))
        else $error("padding reported with bad total length");

endmodule

bind ipv4_header_check_core ihc_checker u_ihc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
